>>> src/spsv_pkg.sv
// Shared types, codes and constants of the segmented prime sieve.
`default_nettype none
package spsv_pkg;

	localparam int unsigned SEGMENT_LEN_DEF = 4096;
	localparam int unsigned PRIME_DEPTH_DEF = 1024;

	localparam int unsigned NUM_W   = 48;
	localparam int unsigned PRIME_W = 24;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned CNT_O_W = 13;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_SIEVE = 2'd1;
	localparam logic [1:0] FUNC_DRAIN = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_LONG = 2'd1;
	localparam logic [1:0] STATUS_REV  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [IDX_W-1:0]   prime_index;
		logic [PRIME_W-1:0] prime_value;
		logic [NUM_W-1:0]   lower_bound;
		logic [NUM_W-1:0]   upper_bound;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [CNT_O_W-1:0] prime_count;
		logic [NUM_W-1:0]   prime_out;
		logic               prime_valid;
		logic               drain_done;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PRD,
		ST_PGOT,
		ST_PCHK,
		ST_DIV,
		ST_DIVD,
		ST_OFF,
		ST_STRIKE,
		ST_CNT,
		ST_CNTE,
		ST_COMMIT,
		ST_DRAIN,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

>>> src/spsv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module spsv_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/spsv_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module spsv_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [spsv_pkg::NUM_W-1:0]    dividend,
	input  wire logic [spsv_pkg::PRIME_W-1:0]  divisor,
	output logic                               done,
	output logic      [spsv_pkg::NUM_W-1:0]    quot,
	output logic      [spsv_pkg::PRIME_W-1:0]  rem
);
	import spsv_pkg::*;

	localparam int unsigned STEP_W = $clog2(NUM_W);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W-1:0]   dvd_q;
	logic [PRIME_W-1:0] rem_q;
	logic [PRIME_W-1:0] d_q;
	logic [PRIME_W:0]   trial;
	logic               fits;

	// Shift in the next dividend bit and try a subtraction
	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits fill the dividend register from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], fits};
			rem_q <= fits ? PRIME_W'(trial - {1'b0, d_q}) : trial[PRIME_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

>>> src/segmented_prime_sieve.sv
// Segmented prime sieve: one item at a time. A load item is answered straight from idle, as is
// a drain item when empty; else a drain scans the flags to the next survivor. A sieve item
// presets the flags, then per table prime whose square fits the bound runs the serial divider
// (48 steps) and strikes odd multiples, then counts the surviving flags.
// Reset clears the control state, the segment and the count; the sifting count resets
// to 1. The prime table and the flag store hold no defined contents after reset.
`default_nettype none
module segmented_prime_sieve #(
	parameter int unsigned SEGMENT_LEN = spsv_pkg::SEGMENT_LEN_DEF,
	parameter int unsigned PRIME_DEPTH = spsv_pkg::PRIME_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire spsv_pkg::cmd_t             cmd,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output spsv_pkg::rsp_t                  rsp,
	input  wire logic                       cfg_we,
	input  wire logic [spsv_pkg::IDX_W-1:0] cfg_data
);
	import spsv_pkg::*;

	localparam int unsigned FA_W = $clog2(SEGMENT_LEN);
	localparam int unsigned FC_W = $clog2(SEGMENT_LEN + 1);
	localparam int unsigned PA_W = $clog2(PRIME_DEPTH);
	localparam int unsigned OFF_W = NUM_W + 2;

	state_t state_q, state_d;

	logic [IDX_W-1:0]   num_sift_q;
	logic [NUM_W-1:0]   base_q;
	logic [FC_W-1:0]    len_q;
	logic [FC_W-1:0]    surv_q;
	logic [FC_W-1:0]    drain_pos_q;
	logic [FC_W-1:0]    emitted_q;

	logic [NUM_W-1:0]   lo_q, hi_q;
	logic [FC_W-1:0]    span_q;
	logic [FC_W-1:0]    scan_q;
	logic [FC_W-1:0]    cnt_q;
	logic [PA_W:0]      idx_q;
	logic [PA_W-1:0]    last_q;
	logic [PRIME_W-1:0] p_q;
	logic [NUM_W-1:0]   sq_q;
	logic [NUM_W:0]     s_q;
	logic [PRIME_W-1:0] off0_q;
	logic [OFF_W-1:0]   offset_q;
	logic               chk_v_s1;
	logic [FC_W-1:0]    chk_addr_s1;
	rsp_t               pend_q;
	rsp_t               out_q;
	logic               out_valid_q;

	logic               slot_free, cmd_acc;
	logic               res_load;
	rsp_t               res_d;
	logic               div_start, div_done;
	logic [NUM_W-1:0]   div_quot;
	logic [PRIME_W-1:0] div_rem;

	logic               tab_we;
	logic [PA_W-1:0]    tab_waddr, tab_raddr;
	logic [PRIME_W-1:0] tab_rdata;
	logic               flag_we, flag_wdata, flag_rd;
	logic [FA_W-1:0]    flag_waddr, flag_raddr;
	logic               flag_rdata;

	logic [NUM_W-1:0]   lo1, lo2;
	logic               rev, too_long;
	logic [NUM_W:0]     span_w;
	logic [31:0]        idx_ext, last_w;
	logic               load_ok, drain_empty, immediate;
	logic               strike_go, found, sq_over;
	logic [NUM_W:0]     s_odd;
	logic               clamp;
	logic [OFF_W-1:0]   offset_d;

	// Interval checks on the incoming item
	always_comb begin
		lo1 = (cmd.lower_bound == '0) ? NUM_W'(1) : cmd.lower_bound;
		rev = lo1 > cmd.upper_bound;
		lo2 = (lo1 == NUM_W'(1)) ? NUM_W'(2) : lo1;
		span_w = (lo2 > cmd.upper_bound) ? '0 :
			(NUM_W + 1)'({1'b0, cmd.upper_bound} - {1'b0, lo2} + 1'b1);
		too_long = span_w > (NUM_W + 1)'(SEGMENT_LEN);
		idx_ext = 32'(cmd.prime_index);
		load_ok = idx_ext < PRIME_DEPTH;
		last_w = (32'(num_sift_q) > PRIME_DEPTH - 1) ? 32'(PRIME_DEPTH - 1) : 32'(num_sift_q);
		drain_empty = emitted_q == surv_q;
		case (cmd.func)
			FUNC_SIEVE: immediate = rev || too_long;
			FUNC_DRAIN: immediate = drain_empty;
			default:    immediate = 1'b1;
		endcase
	end

	assign slot_free = !out_valid_q || !rsp_stall;
	assign cmd_stall = !((state_q == ST_IDLE) && slot_free);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// Strike and offset arithmetic
	always_comb begin
		strike_go = offset_q < OFF_W'(span_q);
		found     = chk_v_s1 && flag_rdata;
		sq_over   = sq_q > hi_q;
		s_odd     = s_q | (NUM_W + 1)'(1);
		clamp     = s_odd < (NUM_W + 1)'(p_q);
		offset_d  = clamp ? OFF_W'(sq_q - lo_q)
			: OFF_W'({1'b0, off0_q} + (s_q[0] ? '0 : {1'b0, p_q}));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && !immediate) begin
					state_d = (cmd.func == FUNC_SIEVE) ? ST_INIT : ST_DRAIN;
				end
			end
			ST_INIT: begin
				if (scan_q == span_q) state_d = ST_PRD;
			end
			ST_PRD: begin
				if (span_q == '0 || idx_q > {1'b0, last_q}) state_d = ST_CNT;
				else state_d = ST_PGOT;
			end
			ST_PGOT:   state_d = ST_PCHK;
			ST_PCHK: begin
				if (p_q == '0) state_d = ST_PRD;
				else if (sq_over) state_d = ST_CNT;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_DIVD;
			end
			ST_DIVD:   state_d = ST_OFF;
			ST_OFF:    state_d = ST_STRIKE;
			ST_STRIKE: begin
				if (!strike_go) state_d = ST_PRD;
			end
			ST_CNT: begin
				if (scan_q == span_q) state_d = ST_CNTE;
			end
			ST_CNTE:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_FIN;
			ST_DRAIN: begin
				if (found) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory ports, divider start, result load
	always_comb begin
		tab_we     = (state_q == ST_IDLE) && cmd_acc && (cmd.func == FUNC_LOAD) && load_ok;
		tab_waddr  = idx_ext[PA_W-1:0];
		tab_raddr  = idx_q[PA_W-1:0];
		flag_we    = ((state_q == ST_INIT) && (scan_q != span_q)) ||
			((state_q == ST_STRIKE) && strike_go);
		flag_waddr = (state_q == ST_STRIKE) ? offset_q[FA_W-1:0] : scan_q[FA_W-1:0];
		flag_wdata = (state_q == ST_INIT) &&
			((lo_q[0] ^ scan_q[0]) || (lo_q == NUM_W'(2) && scan_q == '0));
		flag_raddr = scan_q[FA_W-1:0];
		flag_rd    = ((state_q == ST_CNT) && (scan_q != span_q)) || (state_q == ST_DRAIN);
		div_start  = (state_q == ST_PCHK) && (p_q != '0) && !sq_over;
		res_load   = 1'b0;
		res_d      = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				res_load          = cmd_acc && immediate;
				res_d.status      = STATUS_OK;
				if (cmd.func == FUNC_SIEVE) begin
					res_d.status = rev ? STATUS_REV : STATUS_LONG;
				end
				res_d.prime_count = CNT_O_W'(surv_q);
				res_d.prime_out   = '0;
				res_d.prime_valid = 1'b0;
				res_d.drain_done  = drain_empty;
			end
			ST_FIN:  res_load = slot_free;
			default: res_load = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_sift_q  <= IDX_W'(1);
			base_q      <= '0;
			len_q       <= '0;
			surv_q      <= '0;
			drain_pos_q <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
			chk_v_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			chk_v_s1 <= flag_rd;
			if (cfg_we) num_sift_q <= cfg_data;
			if (res_load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			if (state_q == ST_COMMIT) begin
				base_q      <= lo_q;
				len_q       <= span_q;
				surv_q      <= cnt_q;
				drain_pos_q <= '0;
				emitted_q   <= '0;
			end
			if (state_q == ST_DRAIN && found) begin
				drain_pos_q <= chk_addr_s1 + 1'b1;
				emitted_q   <= emitted_q + 1'b1;
			end
			if (state_q == ST_IDLE && cmd_acc && cmd.func == FUNC_DRAIN && drain_empty) begin
				drain_pos_q <= len_q;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		chk_addr_s1 <= scan_q;
		if (res_load) out_q <= res_d;
		if (state_d == ST_CNT && state_q != ST_CNT) scan_q <= '0;
		case (state_q)
			ST_IDLE: begin
				lo_q   <= lo2;
				hi_q   <= cmd.upper_bound;
				span_q <= FC_W'(span_w);
				last_q <= last_w[PA_W-1:0];
				idx_q  <= (PA_W + 1)'(2);
				cnt_q  <= '0;
				scan_q <= (cmd.func == FUNC_DRAIN) ? drain_pos_q : '0;
			end
			ST_INIT: begin
				if (scan_q != span_q) scan_q <= scan_q + 1'b1;
			end
			ST_PGOT: begin
				p_q  <= tab_rdata;
				sq_q <= NUM_W'(tab_rdata * tab_rdata);
			end
			ST_PCHK: begin
				if (p_q == '0) idx_q <= idx_q + 1'b1;
			end
			ST_DIVD: begin
				s_q    <= {1'b0, div_quot} + (NUM_W + 1)'(div_rem != '0);
				off0_q <= (div_rem == '0) ? '0 : PRIME_W'(p_q - div_rem);
			end
			ST_OFF: offset_q <= offset_d;
			ST_STRIKE: begin
				if (strike_go) offset_q <= offset_q + OFF_W'({p_q, 1'b0});
				else idx_q <= idx_q + 1'b1;
			end
			ST_CNT: begin
				if (scan_q != span_q) scan_q <= scan_q + 1'b1;
				if (chk_v_s1 && flag_rdata) cnt_q <= cnt_q + 1'b1;
			end
			ST_CNTE: begin
				if (chk_v_s1 && flag_rdata) cnt_q <= cnt_q + 1'b1;
			end
			ST_COMMIT: begin
				pend_q.status      <= STATUS_OK;
				pend_q.prime_count <= CNT_O_W'(cnt_q);
				pend_q.prime_out   <= '0;
				pend_q.prime_valid <= 1'b0;
				pend_q.drain_done  <= cnt_q == '0;
			end
			ST_DRAIN: begin
				scan_q <= scan_q + 1'b1;
				if (found) begin
					pend_q.status      <= STATUS_OK;
					pend_q.prime_count <= CNT_O_W'(surv_q);
					pend_q.prime_out   <= NUM_W'(base_q + NUM_W'(chk_addr_s1));
					pend_q.prime_valid <= 1'b1;
					pend_q.drain_done  <= (emitted_q + 1'b1) == surv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	spsv_ram #(
		.WIDTH(PRIME_W),
		.DEPTH(PRIME_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (cmd.prime_value),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	spsv_ram #(
		.WIDTH(1),
		.DEPTH(SEGMENT_LEN)
	) u_flags (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (flag_raddr),
		.rdata (flag_rdata)
	);

	spsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lo_q),
		.divisor  (p_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);
endmodule
`default_nettype wire

>>> verif/tb_segmented_prime_sieve.sv
// Self-checking testbench for the segmented prime sieve: prediction, scoreboard and stimulus.
`timescale 1ns / 1ps
`default_nettype none
module tb_segmented_prime_sieve;
	import spsv_pkg::*;

	localparam int unsigned SEG = 4096;
	localparam int unsigned DEPTH = 1024;

	// Sieve predictor with its own copy of the block state
	class sieve_scoreboard;
		logic [PRIME_W-1:0] table_q [DEPTH];
		bit                 flags [SEG];
		logic [NUM_W-1:0]   seg_base;
		int unsigned        seg_len;
		int unsigned        drain_pos;
		int unsigned        surv_cnt;
		int unsigned        sift_last;
		rsp_t               pending [$];
		int                 errors;

		function void reset_state();
			seg_base = '0; seg_len = 0; drain_pos = 0; surv_cnt = 0;
			sift_last = 1; errors = 0;
			foreach (table_q[i]) table_q[i] = '0;
			foreach (flags[i]) flags[i] = 1'b0;
		endfunction

		function int unsigned scan_from(int unsigned pos);
			while (pos < seg_len && !flags[pos]) pos++;
			return pos;
		endfunction

		function logic [1:0] sieve(logic [NUM_W-1:0] lo_in, logic [NUM_W-1:0] hi);
			logic [63:0] lo, span, p, start, n;
			int unsigned cnt, last;
			lo = 64'(lo_in);
			if (lo == 0) lo = 1;
			if (lo > hi) return STATUS_REV;
			if (lo == 1) lo = 2;
			span = (lo > hi) ? 64'd0 : 64'(hi) - lo + 64'd1;
			if (span > SEG) return STATUS_LONG;
			for (int i = 0; i < span; i++)
				flags[i] = ((lo + i) & 1) || ((lo + i) == 2);
			last = (sift_last > DEPTH - 1) ? DEPTH - 1 : sift_last;
			for (int i = 2; i <= last && span > 0; i++) begin
				p = 64'(table_q[i]);
				if (p == 0) continue;
				if (p * p > hi) break;
				start = lo / p + ((lo % p) ? 1 : 0);
				if (!start[0]) start++;
				if (start < p) start = p;
				for (n = start * p; n <= hi; n += 2 * p) flags[n - lo] = 1'b0;
			end
			cnt = 0;
			for (int i = 0; i < span; i++) cnt += flags[i];
			seg_base = NUM_W'(lo); seg_len = 32'(span); surv_cnt = cnt; drain_pos = 0;
			return STATUS_OK;
		endfunction

		// Note an accepted command and queue its expected response
		function void note_cmd(cmd_t c);
			rsp_t r;
			int unsigned pos;
			r = '0;
			if (c.func == FUNC_LOAD) begin
				table_q[c.prime_index] = c.prime_value;
			end else if (c.func == FUNC_SIEVE) begin
				r.status = sieve(c.lower_bound, c.upper_bound);
			end else if (c.func == FUNC_DRAIN) begin
				pos = scan_from(drain_pos);
				if (pos < seg_len) begin
					r.prime_out = NUM_W'(seg_base + NUM_W'(pos));
					r.prime_valid = 1'b1;
					drain_pos = pos + 1;
				end else begin
					drain_pos = seg_len;
				end
			end
			r.prime_count = CNT_O_W'(surv_cnt);
			r.drain_done = scan_from(drain_pos) >= seg_len;
			pending.push_back(r);
		endfunction

		// Check a response against the oldest expectation
		function void check_rsp(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, a.status); errors++;
			end
			if (a.prime_count !== e.prime_count) begin
				$display("%0t: prime_count exp %0d got %0d", $time, e.prime_count,
					a.prime_count); errors++;
			end
			if (a.prime_out !== e.prime_out) begin
				$display("%0t: prime_out exp %0d got %0d", $time, e.prime_out, a.prime_out);
				errors++;
			end
			if (a.prime_valid !== e.prime_valid) begin
				$display("%0t: prime_valid exp %0b got %0b", $time, e.prime_valid,
					a.prime_valid); errors++;
			end
			if (a.drain_done !== e.drain_done) begin
				$display("%0t: drain_done exp %0b got %0b", $time, e.drain_done,
					a.drain_done); errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	cmd_t             cmd = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_data = '0;
	bit               rsp_stall_en = 1'b1;
	int unsigned      rsp_wait = 0;
	sieve_scoreboard  sb;

	int unsigned primes [$] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
		59, 61, 67, 71, 73, 79, 83, 89, 97};

	always #5 clk = ~clk;

	segmented_prime_sieve u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Check each response transfer and draw the receiver wait for the next one
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_rsp(rsp);
			rsp_wait = rsp_stall_en ? $urandom_range(0, 6) : 0;
		end else if (rsp_valid && rsp_wait != 0) begin
			rsp_wait--;
		end
		rsp_stall <= (rsp_wait != 0);
	end

	// Send one command after a random gap, hold until transferred
	task automatic send_cmd(cmd_t c, bit gaps = 1'b1);
		int unsigned gap;
		gap = gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_sift(logic [IDX_W-1:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.sift_last = 32'(v);
	endtask

	function automatic cmd_t make_cmd(logic [1:0] f);
		cmd_t c;
		c = '0;
		c.func = f;
		c.prime_index = IDX_W'($urandom);
		c.prime_value = PRIME_W'($urandom);
		c.lower_bound = NUM_W'({$urandom, $urandom});
		c.upper_bound = NUM_W'({$urandom, $urandom});
		return c;
	endfunction

	function automatic cmd_t make_sieve(logic [NUM_W-1:0] lo, logic [NUM_W-1:0] hi);
		cmd_t c;
		c = make_cmd(FUNC_SIEVE);
		c.lower_bound = lo;
		c.upper_bound = hi;
		return c;
	endfunction

	function automatic cmd_t make_load(int unsigned idx, int unsigned val);
		cmd_t c;
		c = make_cmd(FUNC_LOAD);
		c.prime_index = IDX_W'(idx);
		c.prime_value = PRIME_W'(val);
		return c;
	endfunction

	initial begin
		logic [NUM_W-1:0] lo;
		int unsigned len, k, sel;
		sb = new();
		sb.reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty drain, trivial intervals, reversed, too long, undefined function
		send_cmd(make_cmd(FUNC_DRAIN));
		send_cmd(make_sieve(48'd1, 48'd1));
		send_cmd(make_sieve(48'd0, 48'd20));
		send_cmd(make_cmd(FUNC_DRAIN));
		send_cmd(make_sieve(48'd50, 48'd10));
		send_cmd(make_sieve(48'd1, 48'd4098));
		send_cmd(make_sieve(48'd100, 48'd100 + NUM_W'(SEG)));
		send_cmd(make_cmd(2'd3));
		// Load the first primes, a zero entry and an index beyond the used ones
		for (int i = 0; i < primes.size(); i++) send_cmd(make_load(i + 1, primes[i]), 1'b0);
		send_cmd(make_load(1023, 24'hFFFFFF));
		send_cmd(make_load(0, 0));
		write_sift(10);
		send_cmd(make_sieve(48'd1, 48'd60));
		for (int i = 0; i < 20; i++) send_cmd(make_cmd(FUNC_DRAIN));
		send_cmd(make_sieve(48'hFFFFFFFFFFFF - 48'd50, 48'hFFFFFFFFFFFF));
		send_cmd(make_cmd(FUNC_DRAIN));
		// Wait for all responses before the next setting
		write_sift(25);
		send_cmd(make_load(26, 0));
		send_cmd(make_sieve(48'd1, NUM_W'(SEG)));
		write_sift(1023);

		// Random phases, mostly drains between sieves, mostly small spans
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_sift(1);
				1: write_sift(5);
				2: write_sift(25);
				default: write_sift(26);
			endcase
			for (int n = 0; n < 20; n++) begin
				sel = $urandom_range(0, 9);
				if (sel < 3) begin
					len = ($urandom_range(0, 19) == 0) ? SEG : $urandom_range(1, 200);
					lo = ($urandom_range(0, 3) == 0) ? NUM_W'({$urandom, $urandom}) :
						NUM_W'($urandom_range(0, 10000));
					if ($urandom_range(0, 9) == 0)
						send_cmd(make_sieve(lo, lo - NUM_W'($urandom_range(1, 5))));
					else
						send_cmd(make_sieve(lo, lo + NUM_W'(len) - 48'd1 +
							(($urandom_range(0, 9) == 0) ? 48'd2 : 48'd0)));
				end else if (sel < 9) begin
					send_cmd(make_cmd(FUNC_DRAIN));
				end else if (sel == 9 && $urandom_range(0, 1)) begin
					send_cmd(make_cmd(2'd3));
				end else begin
					// Reload a used entry with the same prime; other bits stay random
					k = $urandom_range(1, 25);
					send_cmd(make_load(k, primes[k - 1]));
				end
			end
			// Also touch high index and data bits via an unused entry
			send_cmd(make_load($urandom_range(900, 1023), $urandom));
		end
		wait_idle();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

>>> segmented_prime_sieve.f
src/spsv_pkg.sv
src/spsv_ram.sv
src/spsv_div.sv
src/segmented_prime_sieve.sv
verif/tb_segmented_prime_sieve.sv
